>>> design/mm_pkg.sv
// Shared types and codes for the matrix multiply block.
// No dependencies; used by mm_cell and matrix_multiply.
`default_nettype none

package mm_pkg;

  // Input mode codes
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT   = 2'd2;

  localparam int unsigned ACC_W  = 40;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 32;

  // Token passed from cell to cell: one product element in flight
  typedef struct packed {
    logic                    vld;
    logic                    last;
    logic [2:0]              row;
    logic [2:0]              col;
    logic signed [ACC_W-1:0] acc;
  } mm_tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } mm_state_t;

endpackage

`default_nettype wire

>>> design/matrix_multiply.sv
// Top level of the fixed-point matrix multiply: sequencer, config and cell chain.
// Depends on mm_pkg, mm_cell and mm_ram.
//
// Usage
//  - Input channel (in_valid / in_stall): load words (mode A or B) write one
//    Q8.8 element each; a compute word starts a run.
//  - Output channel (out_valid / out_stall): one word per product element,
//    row-major, out_last on the final one. product_value is exact Q24.16.
//  - Config port: cfg_we with cfg_index 0 rows, 1 inner, 2 cols; write only
//    while idle. Counts of 0 act as 1, counts above min(8, MAX_DIM) are capped.
// Pipeline and throughput
//  - A chain of MAX_DIM cells, three stages each (RAM read, multiply, add).
//  - Elements are issued and product words leave at one per cycle while the
//    chain is not frozen by out_stall.
//  - in_stall stays high from a compute word until its last word is taken.
// Reset and stall
//  - Synchronous active-low reset clears control state and sets all counts to
//    8; matrix contents are undefined until written.
//  - out_stall with out_valid high freezes the whole chain; output payload holds while stalled.
`default_nettype none

module matrix_multiply #(
  parameter int unsigned MAX_DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [2:0]         in_row_index,
  input  wire logic [2:0]         in_col_index,
  input  wire logic signed [15:0] in_element_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [39:0]      out_product_value,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic                    out_last,
  // configuration port
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_wdata
);

  localparam int unsigned AW      = $clog2(MAX_DIM);
  localparam int unsigned DIM_CAP = (MAX_DIM < 8) ? MAX_DIM : 8;

  // clamp a count register to 1..DIM_CAP
  function automatic logic [3:0] clamp_count(input logic [3:0] v);
    logic [3:0] res;
    res = v;
    if (v == 4'd0) begin
      res = 4'd1;
    end else if (32'(v) > DIM_CAP) begin
      res = 4'(DIM_CAP);
    end
    return res;
  endfunction

  // config registers
  logic [3:0] row_count_r;
  logic [3:0] inner_count_r;
  logic [3:0] col_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r   <= 4'd8;
      inner_count_r <= 4'd8;
      col_count_r   <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        mm_pkg::REG_ROW_COUNT:   row_count_r   <= cfg_wdata;
        mm_pkg::REG_INNER_COUNT: inner_count_r <= cfg_wdata;
        mm_pkg::REG_COL_COUNT:   col_count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer state
  mm_pkg::mm_state_t state_r, state_nxt;
  logic [2:0] i_r, i_nxt;
  logic [2:0] j_r, j_nxt;
  logic [3:0] rows_r, rows_nxt;
  logic [3:0] cols_r, cols_nxt;
  logic [3:0] inner_r, inner_nxt;

  logic            in_acc;
  logic            adv;
  logic            issue_last;
  mm_pkg::mm_tok_t tok_first;
  mm_pkg::mm_tok_t tok_chain [MAX_DIM+1];

  assign in_acc = in_valid && !in_stall;
  // whole chain moves unless a finished word is held by the receiver
  assign adv    = !(out_valid && out_stall);

  assign issue_last = (4'(i_r) + 4'd1 == rows_r) && (4'(j_r) + 4'd1 == cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    inner_r <= inner_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    inner_nxt = inner_r;
    in_stall  = (state_r != mm_pkg::ST_IDLE);
    case (state_r)
      mm_pkg::ST_IDLE: begin
        if (in_acc && in_mode == mm_pkg::MODE_COMPUTE) begin
          // latch the clamped counts for the whole run
          rows_nxt  = clamp_count(row_count_r);
          cols_nxt  = clamp_count(col_count_r);
          inner_nxt = clamp_count(inner_count_r);
          i_nxt     = 3'd0;
          j_nxt     = 3'd0;
          state_nxt = mm_pkg::ST_ISSUE;
        end
      end
      mm_pkg::ST_ISSUE: begin
        if (adv) begin
          if (issue_last) begin
            state_nxt = mm_pkg::ST_DRAIN;
          end else if (4'(j_r) + 4'd1 == cols_r) begin
            j_nxt = 3'd0;
            i_nxt = i_r + 3'd1;
          end else begin
            j_nxt = j_r + 3'd1;
          end
        end
      end
      mm_pkg::ST_DRAIN: begin
        if (out_valid && !out_stall && out_last) begin
          state_nxt = mm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mm_pkg::ST_IDLE;
    endcase
  end

  // token entering the first cell
  always_comb begin
    tok_first.vld  = (state_r == mm_pkg::ST_ISSUE);
    tok_first.last = issue_last;
    tok_first.row  = i_r;
    tok_first.col  = j_r;
    tok_first.acc  = '0;
  end

  assign tok_chain[0] = tok_first;

  // load decode: A(r,k) goes to cell k, B(k,c) goes to cell k
  logic load_a;
  logic load_b;
  logic row_ok;
  logic col_ok;

  assign load_a = in_acc && (in_mode == mm_pkg::MODE_LOAD_A);
  assign load_b = in_acc && (in_mode == mm_pkg::MODE_LOAD_B);
  assign row_ok = (32'(in_row_index) < MAX_DIM);
  assign col_ok = (32'(in_col_index) < MAX_DIM);

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
    logic a_we;
    logic b_we;
    logic active;

    assign a_we   = load_a && row_ok && (32'(in_col_index) == k);
    assign b_we   = load_b && col_ok && (32'(in_row_index) == k);
    // cells beyond the inner count pass the sum through
    assign active = (32'(inner_r) > k);

    mm_cell #(.DIM(MAX_DIM)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .active  (active),
      .a_we    (a_we),
      .a_waddr (AW'(in_row_index)),
      .b_we    (b_we),
      .b_waddr (AW'(in_col_index)),
      .wdata   (in_element_value),
      .tok_in  (tok_chain[k]),
      .tok_out (tok_chain[k+1])
    );
  end

  // output word comes straight from the last cell's register
  assign out_valid         = tok_chain[MAX_DIM].vld;
  assign out_product_value = tok_chain[MAX_DIM].acc;
  assign out_row           = tok_chain[MAX_DIM].row;
  assign out_col           = tok_chain[MAX_DIM].col;
  assign out_last          = tok_chain[MAX_DIM].last;

endmodule

`default_nettype wire

>>> design/mm_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none

module mm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/mm_cell.sv
// One multiply-accumulate cell of the chain: holds column k of A and row k of B.
// Depends on mm_pkg and mm_ram.
`default_nettype none

module mm_cell #(
  parameter int unsigned DIM = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   adv,
  input  wire logic                   active,
  input  wire logic                   a_we,
  input  wire logic [$clog2(DIM)-1:0] a_waddr,
  input  wire logic                   b_we,
  input  wire logic [$clog2(DIM)-1:0] b_waddr,
  input  wire logic [mm_pkg::ELEM_W-1:0] wdata,
  input  wire mm_pkg::mm_tok_t        tok_in,
  output mm_pkg::mm_tok_t             tok_out
);

  localparam int unsigned AW = $clog2(DIM);

  logic [mm_pkg::ELEM_W-1:0]        a_q;
  logic [mm_pkg::ELEM_W-1:0]        b_q;
  logic signed [mm_pkg::PROD_W-1:0] prod_r;
  logic signed [mm_pkg::PROD_W-1:0] prod_nxt;
  mm_pkg::mm_tok_t                  tok1_r;
  mm_pkg::mm_tok_t                  tok2_r;
  mm_pkg::mm_tok_t                  tok_out_r;
  mm_pkg::mm_tok_t                  tok_out_nxt;

  // A(r,k) at address r
  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DIM)) u_a_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (AW'(tok_in.row)),
    .rdata (a_q)
  );

  // B(k,c) at address c
  mm_ram #(.WIDTH(mm_pkg::ELEM_W), .DEPTH(DIM)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (AW'(tok_in.col)),
    .rdata (b_q)
  );

  assign prod_nxt = $signed(a_q) * $signed(b_q);

  always_comb begin
    tok_out_nxt = tok2_r;
    if (active) begin
      tok_out_nxt.acc = tok2_r.acc + mm_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok1_r.vld    <= 1'b0;
      tok2_r.vld    <= 1'b0;
      tok_out_r.vld <= 1'b0;
    end else if (adv) begin
      tok1_r    <= tok_in;
      tok2_r    <= tok1_r;
      prod_r    <= prod_nxt;
      tok_out_r <= tok_out_nxt;
    end
  end

  assign tok_out = tok_out_r;

endmodule

`default_nettype wire
